/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the PID block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk outside reset.
`define PTFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset.
`define PTFD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/ptfd_pkg.sv */
// Shared constants and types of the Tustin-filtered PID block.
`default_nettype none

package ptfd_pkg;

    // Coefficient register widths (unsigned Q15.16 gains and the signed filter pole)
    localparam int COEF_W    = 31;
    localparam int POLE_W    = 18;
    localparam int CFG_IDX_W = 2;

    // Scaled products are clamped to +-2^56; one extra step below that on
    // the negative side needs a 58-bit signed carrier
    localparam int WIDE_LIMIT_LOG2 = 56;
    localparam int WIDE_W          = 58;

    // Reset values of the coefficient registers
    localparam logic [COEF_W-1:0]        PROP_GAIN_RST  = 31'd78643;
    localparam logic [COEF_W-1:0]        INTEG_COEF_RST = 31'd0;
    localparam logic [COEF_W-1:0]        DERIV_COEF_RST = 31'd2506690;
    localparam logic signed [POLE_W-1:0] DERIV_POLE_RST = 18'sd34203;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_COEF = 2'd1,
        REG_DERIV_COEF = 2'd2,
        REG_DERIV_POLE = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/ptfd_mulq.sv */
// Signed fixed-point multiply, floored to the fraction grid, clamped to +-2^56.
`default_nettype none

module ptfd_mulq
    import ptfd_pkg::*;
#(
    parameter int A_W       = 33,
    parameter int C_W       = 32,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic signed [A_W-1:0]    a,
    input  wire logic signed [C_W-1:0]    c,
    output logic signed [WIDE_W-1:0]      q
);

    localparam int P_W = A_W + C_W;
    localparam int M_W = (P_W > WIDE_W + 2) ? P_W : WIDE_W + 2;
    localparam logic [M_W-1:0] LIMIT = M_W'(1) << WIDE_LIMIT_LOG2;

    logic signed [P_W-1:0] prod;
    logic [P_W-1:0]        mag;
    logic [M_W-1:0]        quo;
    logic                  neg;
    logic                  rem_nz;
    logic                  clamp;
    logic [WIDE_W-1:0]     r_mag;

    assign prod   = a * c;
    assign neg    = prod[P_W-1];
    assign mag    = neg ? P_W'(-prod) : P_W'(prod);
    assign quo    = M_W'(mag) >> FRAC_BITS;
    assign rem_nz = |mag[FRAC_BITS-1:0];
    assign clamp  = quo > LIMIT;

    // Round the magnitude up for negative products so the signed result is
    // floored; a clamped magnitude takes no rounding step
    always_comb
    begin
        if (clamp)
        begin
            r_mag = LIMIT[WIDE_W-1:0];
        end
        else
        begin
            r_mag = quo[WIDE_W-1:0] + WIDE_W'(neg && rem_nz);
        end
    end

    assign q = signed'(neg ? (~r_mag + WIDE_W'(1)) : r_mag);

endmodule

`default_nettype wire

/* rtl/pid_tustin_filtered_derivative.sv */
// Top level: discrete PID with trapezoidal integral and Tustin-filtered derivative.
//
// Usage: one slave-side transaction carries the present and previous control
// error (signed fixed point, FRAC_BITS fraction bits); one master-side
// transaction returns the saturated drive value and a flag that is set when
// the proportional, integral or derivative term or their sum was clipped.
// Gains and the filter pole sit in four registers written through the plain
// write port (index 0 prop_gain, 1 integ_coef, 2 deriv_coef, 3 deriv_pole);
// write them only while no transaction is in flight.
// The result passes the input register, product stage, state-update stage
// and output register before it shows on m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; the integral and
// filtered derivative recurrence closes in the state-update stage, one
// multiply by the pole plus an add and a clip; back-to-back items need no wait.
// When the receiver holds m_tready low with a result waiting, every stage
// holds and s_tready drops in the same cycle; bubbles between items hold
// as well. Reset clears the stage valid bits, empties the pipe, zeroes
// the integral and derivative state and loads the default coefficients.
`default_nettype none

`include "assert_macros.svh"

module pid_tustin_filtered_derivative
    import ptfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // Configuration write port
    input  wire logic                                    cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]                    cfg_addr,
    input  wire logic [COEF_W-1:0]                       cfg_wdata,
    // Error stream
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // s_tdata fields, low bit up: error_now, error_prev
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    // Drive stream
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // m_tdata fields, low bit up: drive_value
    output logic [((DATA_WIDTH+7)/8)*8-1:0]              m_tdata,
    // m_tuser fields, low bit up: saturated
    output logic                                         m_tuser
);

    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int SUM_W     = WIDE_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Clip a wide sum to the signed DATA_WIDTH range
    function automatic logic signed [DATA_WIDTH-1:0] clip_val(
        input logic signed [SUM_W-1:0] v
    );
        if (v > SAT_HI)
        begin
            clip_val = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            clip_val = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            clip_val = v[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic logic is_clip(input logic signed [SUM_W-1:0] v);
        is_clip = (v > SAT_HI) || (v < SAT_LO);
    endfunction

    // Coefficient registers
    logic [COEF_W-1:0]        prop_gain_reg;
    logic [COEF_W-1:0]        integ_coef_reg;
    logic [COEF_W-1:0]        deriv_coef_reg;
    logic signed [POLE_W-1:0] deriv_pole_reg;

    // Pipeline valid bits
    logic adv;
    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic vout_reg;

    // Stage A: captured errors
    logic signed [DATA_WIDTH-1:0] err_now_reg;
    logic signed [DATA_WIDTH-1:0] err_prev_reg;

    // Stage B: scaled input products
    logic signed [DATA_WIDTH:0]   err_sum;
    logic signed [DATA_WIDTH:0]   err_diff;
    logic signed [WIDE_W-1:0]     p_q;
    logic signed [WIDE_W-1:0]     i_q;
    logic signed [WIDE_W-1:0]     d_q;
    logic signed [DATA_WIDTH-1:0] pb_reg;
    logic                         fb_reg;
    logic signed [WIDE_W-1:0]     ib_reg;
    logic signed [WIDE_W-1:0]     db_reg;

    // Stage C: recurrence state
    logic signed [WIDE_W-1:0]     pole_q;
    logic signed [SUM_W-1:0]      i_sum;
    logic signed [SUM_W-1:0]      d_sum;
    logic signed [DATA_WIDTH-1:0] integ_reg;
    logic signed [DATA_WIDTH-1:0] deriv_reg;
    logic signed [DATA_WIDTH-1:0] pc_reg;
    logic                         fc_reg;

    // Output stage
    logic signed [SUM_W-1:0]      y_sum;
    logic [DATA_WIDTH-1:0]        drive_reg;
    logic                         sat_reg;

    // ---------------------------------------------------------------
    // Configuration writes; deriv_pole keeps its low bits as signed
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_coef_reg <= INTEG_COEF_RST;
            deriv_coef_reg <= DERIV_COEF_RST;
            deriv_pole_reg <= DERIV_POLE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                REG_INTEG_COEF: integ_coef_reg <= cfg_wdata;
                REG_DERIV_COEF: deriv_coef_reg <= cfg_wdata;
                REG_DERIV_POLE: deriv_pole_reg <= signed'(cfg_wdata[POLE_W-1:0]);
                default:        prop_gain_reg  <= prop_gain_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: all stages advance together unless a result waits
    // ---------------------------------------------------------------
    assign adv      = !vout_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg   <= s_tvalid;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vout_reg <= vc_reg;
        end
    end

    // Stage A: capture the transaction
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_now_reg  <= signed'(s_tdata[DATA_WIDTH-1:0]);
            err_prev_reg <= signed'(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
        end
    end

    // Stage B: products with the configured gains
    assign err_sum  = (DATA_WIDTH+1)'(err_now_reg) + (DATA_WIDTH+1)'(err_prev_reg);
    assign err_diff = (DATA_WIDTH+1)'(err_now_reg) - (DATA_WIDTH+1)'(err_prev_reg);

    ptfd_mulq #(.A_W(DATA_WIDTH), .C_W(COEF_W + 1), .FRAC_BITS(FRAC_BITS)) u_mul_p
    (
        .a (err_now_reg),
        .c (signed'({1'b0, prop_gain_reg})),
        .q (p_q)
    );

    ptfd_mulq #(.A_W(DATA_WIDTH + 1), .C_W(COEF_W + 1), .FRAC_BITS(FRAC_BITS)) u_mul_i
    (
        .a (err_sum),
        .c (signed'({1'b0, integ_coef_reg})),
        .q (i_q)
    );

    ptfd_mulq #(.A_W(DATA_WIDTH + 1), .C_W(COEF_W + 1), .FRAC_BITS(FRAC_BITS)) u_mul_d
    (
        .a (err_diff),
        .c (signed'({1'b0, deriv_coef_reg})),
        .q (d_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pb_reg <= clip_val(SUM_W'(p_q));
            fb_reg <= is_clip(SUM_W'(p_q));
            ib_reg <= i_q;
            db_reg <= d_q;
        end
    end

    // Stage C: close the integral and filtered-derivative recurrence
    ptfd_mulq #(.A_W(DATA_WIDTH), .C_W(POLE_W), .FRAC_BITS(FRAC_BITS)) u_mul_pole
    (
        .a (deriv_reg),
        .c (deriv_pole_reg),
        .q (pole_q)
    );

    assign i_sum = SUM_W'(ib_reg) + SUM_W'(integ_reg);
    assign d_sum = SUM_W'(db_reg) + SUM_W'(pole_q);

    // Update the stored terms only when a real item leaves stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            deriv_reg <= '0;
        end
        else if (adv && vb_reg)
        begin
            integ_reg <= clip_val(i_sum);
            deriv_reg <= clip_val(d_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg <= pb_reg;
            fc_reg <= fb_reg || is_clip(i_sum) || is_clip(d_sum);
        end
    end

    // Output stage: sum the three clipped terms and hold for the receiver
    assign y_sum = SUM_W'(pc_reg) + SUM_W'(integ_reg) + SUM_W'(deriv_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            drive_reg <= unsigned'(clip_val(y_sum));
            sat_reg   <= fc_reg || is_clip(y_sum);
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = M_TDATA_W'(drive_reg);
    assign m_tuser  = sat_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PTFD_ASSERT(a_state_hold, !(adv && vb_reg) |=> $stable(integ_reg) && $stable(deriv_reg),
        "integral or derivative state moved without an item")
    `PTFD_NEVER(a_pole_zero, deriv_reg == '0 && pole_q != '0,
        "pole product of a zero derivative state is not zero")
    `PTFD_ASSERT(a_out_source, $rose(vout_reg) |-> $past(vc_reg),
        "result appeared without an item in the state stage")

endmodule

`default_nettype wire
